// ----- rtl/ctk_pkg.sv -----
// shared types, constants and character classes for the comment-stripping tokenizer
package ctk_pkg;

  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned RES_CNT_W   = 2;
  localparam int unsigned FIFO_DEPTH  = 8;

  localparam logic [1:0] MODE_TEXT  = 2'd0;
  localparam logic [1:0] MODE_BLOCK = 2'd1;
  localparam logic [1:0] MODE_LINE  = 2'd2;
  localparam logic [1:0] MODE_STAR  = 2'd3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic       stream_end;
    logic       token_end;
    logic       byte_valid;
    logic [7:0] token_byte;
  } res_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_group(input logic [7:0] b);
    return (b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_LBRACE) || (b == CH_RBRACE);
  endfunction

  function automatic logic is_delim(input logic [7:0] b);
    return is_group(b) || (b == CH_COMMA) || (b == CH_COLON) || (b == CH_SEMI) ||
           (b == CH_SLASH) || (b == CH_HASH) || (b == CH_LBRACK) || (b == CH_RBRACK) ||
           (b == CH_STAR) || (b == CH_QUOTE) || (b == CH_BSLASH);
  endfunction

endpackage

// ----- rtl/comment_stripping_tokenizer_core.sv -----
// top level: byte-stream tokenizer that strips block, line and hash comments
// One text byte is taken per cycle into an input register. When the queue has room, the
// byte updates the comment/token state and writes its result words (none, one or two)
// into an output queue of FIFO_DEPTH entries, which drains one word per cycle while
// m_tready is high. The input is accepted every cycle as long as the queue has room for a
// worst-case item, so the sustained rate is one byte per cycle while the average is at
// most one word per byte. A byte that yields two words (a group character closing a
// token, or a last ordinary byte added to an open token) is paid for by an earlier byte
// that yielded none. Each word passes through the input register and the output queue.
// FIFO_DEPTH must be a power of two of at least four.
module comment_stripping_tokenizer_core #(
  parameter int unsigned FIFO_DEPTH = ctk_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // stream_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] token_byte, [8] token_end, [15:9] zero
  output logic        m_tuser,   // byte_valid
  output logic        m_tlast    // stream_end
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned MAXR  = ctk_pkg::MAX_RESULTS;
  localparam int unsigned RCW   = ctk_pkg::RES_CNT_W;

  // input register
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_last;

  // tokenizer state
  logic [1:0] mode, mode_next;
  logic       slash_pending, slash_pending_next;
  logic [7:0] held_char, held_char_next;
  logic       held_valid, held_valid_next;
  logic       stopped, stopped_next;

  // output queue
  ctk_pkg::res_t    mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  ctk_pkg::res_t  res [MAXR];
  logic [RCW-1:0] nres;
  logic           room;
  logic           proc;
  logic           pop;
  logic           handled;

  assign room     = count <= CNT_W'(FIFO_DEPTH - MAXR);
  assign proc     = in_full && room;
  assign s_tready = !in_full || proc;
  assign pop      = m_tvalid && m_tready;

  always_comb begin
    mode_next          = mode;
    slash_pending_next = slash_pending;
    held_char_next     = held_char;
    held_valid_next    = held_valid;
    stopped_next       = stopped;
    nres               = '0;
    handled            = 1'b0;
    for (int i = 0; i < MAXR; i++) begin
      res[i] = '0;
    end
    if (!stopped) begin
      case (mode)
        ctk_pkg::MODE_BLOCK: begin
          if (in_byte == ctk_pkg::CH_STAR) mode_next = ctk_pkg::MODE_STAR;
        end
        ctk_pkg::MODE_STAR: begin
          if (in_byte == ctk_pkg::CH_SLASH) mode_next = ctk_pkg::MODE_TEXT;
          else if (in_byte != ctk_pkg::CH_STAR) mode_next = ctk_pkg::MODE_BLOCK;
        end
        ctk_pkg::MODE_LINE: begin
          if (in_byte == ctk_pkg::CH_LF || in_byte == ctk_pkg::CH_CR) begin
            mode_next = ctk_pkg::MODE_TEXT;
          end
        end
        default: begin
          if (slash_pending) begin
            slash_pending_next = 1'b0;
            if (in_byte == ctk_pkg::CH_STAR) begin
              mode_next = ctk_pkg::MODE_BLOCK;
              handled   = 1'b1;
            end else if (in_byte == ctk_pkg::CH_SLASH) begin
              mode_next = ctk_pkg::MODE_LINE;
              handled   = 1'b1;
            end
          end
          if (!handled) begin
            if (in_byte == ctk_pkg::CH_NUL) begin
              stopped_next = 1'b1;
            end else if (ctk_pkg::is_space(in_byte) || ctk_pkg::is_delim(in_byte)) begin
              if (held_valid) begin
                res[nres] = '{stream_end: 1'b0, token_end: 1'b1, byte_valid: 1'b1,
                              token_byte: held_char};
                nres      = nres + RCW'(1);
              end
              held_valid_next = 1'b0;
              held_char_next  = '0;
              if (ctk_pkg::is_group(in_byte)) begin
                res[nres] = '{stream_end: 1'b0, token_end: 1'b1, byte_valid: 1'b1,
                              token_byte: in_byte};
                nres      = nres + RCW'(1);
              end else if (in_byte == ctk_pkg::CH_SLASH) begin
                slash_pending_next = 1'b1;
              end else if (in_byte == ctk_pkg::CH_HASH) begin
                mode_next = ctk_pkg::MODE_LINE;
              end
            end else begin
              if (held_valid) begin
                res[nres] = '{stream_end: 1'b0, token_end: 1'b0, byte_valid: 1'b1,
                              token_byte: held_char};
                nres      = nres + RCW'(1);
              end
              held_char_next  = in_byte;
              held_valid_next = 1'b1;
            end
          end
        end
      endcase
    end
    if (in_last) begin
      // flush the open token, or send a bare end marker
      if (held_valid_next) begin
        res[nres] = '{stream_end: 1'b0, token_end: 1'b1, byte_valid: 1'b1,
                      token_byte: held_char_next};
        nres      = nres + RCW'(1);
      end
      if (nres == '0) begin
        res[nres] = '0;
        nres      = nres + RCW'(1);
      end
      res[nres - RCW'(1)].stream_end = 1'b1;
      mode_next          = ctk_pkg::MODE_TEXT;
      slash_pending_next = 1'b0;
      held_char_next     = '0;
      held_valid_next    = 1'b0;
      stopped_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_full <= 1'b1;
    end else if (proc) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= ctk_pkg::MODE_TEXT;
      slash_pending <= 1'b0;
      held_char     <= '0;
      held_valid    <= 1'b0;
      stopped       <= 1'b0;
    end else if (proc) begin
      mode          <= mode_next;
      slash_pending <= slash_pending_next;
      held_char     <= held_char_next;
      held_valid    <= held_valid_next;
      stopped       <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      for (int i = 0; i < MAXR; i++) begin
        if (RCW'(i) < nres) mem[wptr + PTR_W'(i)] <= res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (proc) wptr <= wptr + PTR_W'(nres);
      if (pop) rptr <= rptr + PTR_W'(1);
      count <= count + (proc ? CNT_W'(nres) : CNT_W'(0)) - (pop ? CNT_W'(1) : CNT_W'(0));
    end
  end

  assign m_tvalid = count != '0;
  assign m_tdata  = {7'd0, mem[rptr].token_end, mem[rptr].token_byte};
  assign m_tuser  = mem[rptr].byte_valid;
  assign m_tlast  = mem[rptr].stream_end;

endmodule

// ----- rtl/ctk_checker.sv -----
// port-level checker for the comment-stripping tokenizer, bound to the top level
module ctk_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
    $stable(m_tlast))
    else $error("output word changed while stalled");

  // bare end marker only closes a stream and carries nothing
  a_bare: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && m_tdata == 16'd0)
    else $error("bare end marker malformed");

  // the final character of a stream always closes its token
  a_flush: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast && m_tuser |-> m_tdata[8])
    else $error("stream ended with open token");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind comment_stripping_tokenizer_core ctk_checker u_ctk_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
